/* hdl/gop_aligned_packet_ring_core_defines.svh */
// Assertion helpers for the packet ring core.
`ifndef GOP_ALIGNED_PACKET_RING_CORE_DEFINES_SVH
`define GOP_ALIGNED_PACKET_RING_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define GAPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define GAPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/gapr_pkg.sv */
package gapr_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int TIME_W    = 64;
  localparam int SIZE_W    = 24;
  localparam int GEN_W     = 32;
  localparam int BYTE_W    = 48;
  localparam int SPAN_W    = 63;
  localparam int INFO_W    = 58;
  localparam int OUT_IDX_W = 12;
  localparam int OUT_CNT_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 64;

  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  // Opcodes on the input channel
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN  = 1'd1;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_RESOLVE,
    CMD_CLEAR,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TIME_W-1:0]  packet_time_ns;
    logic [SIZE_W-1:0]  packet_size;
    logic               is_video;
    logic               is_keyframe;
    logic [GEN_W-1:0]   packet_generation;
    logic [TIME_W-1:0]  range_in_ns;
    logic [TIME_W-1:0]  range_out_ns;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Physical slot of logical index idx counted from the head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, idx};
    if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(RING_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* hdl/gapr_in_if.sv */
interface gapr_in_if import gapr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [TIME_W-1:0] packet_time_ns;
  logic [SIZE_W-1:0] packet_size;
  logic              is_video;
  logic              is_keyframe;
  logic [GEN_W-1:0]  packet_generation;
  logic [TIME_W-1:0] range_in_ns;
  logic [TIME_W-1:0] range_out_ns;

  modport source (output valid, op, packet_time_ns, packet_size, is_video, is_keyframe,
                  packet_generation, range_in_ns, range_out_ns, input ready);
  modport sink (input valid, op, packet_time_ns, packet_size, is_video, is_keyframe,
                packet_generation, range_in_ns, range_out_ns, output ready);
endinterface

/* hdl/gapr_out_if.sv */
interface gapr_out_if import gapr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [OUT_IDX_W-1:0] decode_start_index;
  logic [OUT_IDX_W-1:0] last_index;
  logic [TIME_W-1:0]    decode_start_ns;
  logic [TIME_W-1:0]    present_in_ns;
  logic [TIME_W-1:0]    present_out_ns;
  logic [GEN_W-1:0]     range_generation;
  logic [TIME_W-1:0]    oldest_ns;
  logic [TIME_W-1:0]    newest_ns;
  logic [BYTE_W-1:0]    held_bytes;
  logic [OUT_CNT_W-1:0] held_count;

  modport source (output valid, ok, decode_start_index, last_index, decode_start_ns,
                  present_in_ns, present_out_ns, range_generation, oldest_ns, newest_ns,
                  held_bytes, held_count, input ready);
  modport sink (input valid, ok, decode_start_index, last_index, decode_start_ns,
                present_in_ns, present_out_ns, range_generation, oldest_ns, newest_ns,
                held_bytes, held_count, output ready);
endinterface

/* hdl/gapr_cfg_if.sv */
interface gapr_cfg_if import gapr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/gop_aligned_packet_ring_core.sv */
// Flow: clear and a refused push finish straight from dispatch; a push writes its entry, then checks
//   the limits and scans entries to drop groups by eviction; a resolve runs two scans over the entries.
// Throughput: one item at a time; the scans through the single read port of the entry RAMs
//   set the rate; a two-deep command queue lets input beats land while the engine works.
// Reset: synchronous active-low rst_n empties the ring and zeroes both limits; entry RAMs
//   are not cleared, no reset pass.
module gop_aligned_packet_ring_core import gapr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gapr_in_if.sink    in_ch,
  gapr_out_if.source out_ch,
  gapr_cfg_if.sink   cfg_ch
);

  q_head_t q_head;
  logic    q_pop;

  gapr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  gapr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

/* hdl/gapr_ram.sv */
module gapr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/gapr_front.sv */
module gapr_front import gapr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gapr_in_if.sink   in_ch,
  output q_head_t   q_head,
  input  logic      q_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push;
  logic       pop;

  // Classify the incoming beat
  always_comb begin
    cls.packet_time_ns    = in_ch.packet_time_ns;
    cls.packet_size       = in_ch.packet_size;
    cls.is_video          = in_ch.is_video;
    cls.is_keyframe       = in_ch.is_keyframe;
    cls.packet_generation = in_ch.packet_generation;
    cls.range_in_ns       = in_ch.range_in_ns;
    cls.range_out_ns      = in_ch.range_out_ns;
    unique case (in_ch.op)
      OP_PUSH:    cls.kind = CMD_PUSH;
      OP_RESOLVE: cls.kind = CMD_RESOLVE;
      OP_CLEAR:   cls.kind = CMD_CLEAR;
      default:    cls.kind = CMD_BAD;
    endcase
  end

  assign in_ch.ready  = (cnt_r != 2'd2);
  assign push         = in_ch.valid && in_ch.ready;
  assign pop          = q_pop && (cnt_r != 2'd0);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_r[rd_ptr_r];

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* hdl/gapr_back.sv */
`include "gop_aligned_packet_ring_core_defines.svh"

module gapr_back import gapr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  output logic      q_pop,
  gapr_out_if.source out_ch,
  gapr_cfg_if.sink  cfg_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_EV_CHK = 4'd2;
  localparam logic [3:0] S_EV_RD  = 4'd3;
  localparam logic [3:0] S_EV_DAT = 4'd4;
  localparam logic [3:0] S_R1_RD  = 4'd5;
  localparam logic [3:0] S_R1_DAT = 4'd6;
  localparam logic [3:0] S_R2_RD  = 4'd7;
  localparam logic [3:0] S_R2_DAT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]              state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        total_r, total_nxt;
  logic [BYTE_W-1:0]       bytes_r, bytes_nxt;
  logic signed [TIME_W-1:0] newest_r, newest_nxt;
  logic signed [TIME_W-1:0] oldest_r, oldest_nxt;
  logic [BYTE_W-1:0]       max_bytes_r, max_bytes_nxt;
  logic [SPAN_W-1:0]       max_span_r, max_span_nxt;

  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [BYTE_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]        ds_r, ds_nxt;
  logic [CNT_W-1:0]        last_r, last_nxt;
  logic signed [TIME_W-1:0] ds_time_r, ds_time_nxt;
  logic [GEN_W-1:0]        gen_r, gen_nxt;
  logic                    have_key_r, have_key_nxt;
  logic                    have_in_r, have_in_nxt;
  logic                    have_out_r, have_out_nxt;
  logic signed [TIME_W-1:0] p_in_r, p_in_nxt;
  logic signed [TIME_W-1:0] p_out_r, p_out_nxt;
  logic                    ok_r, ok_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;
  logic                    o_ok_r;
  logic [OUT_IDX_W-1:0]    o_ds_idx_r, o_last_idx_r;
  logic [TIME_W-1:0]       o_ds_ns_r, o_p_in_r, o_p_out_r, o_oldest_r, o_newest_r;
  logic [GEN_W-1:0]        o_gen_r;
  logic [BYTE_W-1:0]       o_bytes_r;
  logic [OUT_CNT_W-1:0]    o_count_r;

  // Ring store
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [INFO_W-1:0]       wr_info, rd_info;
  logic [TIME_W-1:0]       rd_time_raw;
  logic signed [TIME_W-1:0] rd_time;
  logic                    rd_video, rd_keyvid;
  logic [SIZE_W-1:0]       rd_size;
  logic [GEN_W-1:0]        rd_gen;

  logic [CNT_W-1:0]        idx_inc;
  logic [TIME_W-1:0]       span;
  logic                    over_lim;
  logic [BYTE_W:0]         bytes_add;
  logic signed [TIME_W-1:0] c_time, c_rin, c_rout;

  assign ram_waddr = slot_of(head_r, total_r);
  assign ram_raddr = slot_of(head_r, idx_r);
  assign wr_info   = {cmd_r.packet_generation, cmd_r.is_keyframe, cmd_r.is_video,
                      cmd_r.packet_size};

  gapr_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_r.packet_time_ns),
    .raddr (ram_raddr),
    .rdata (rd_time_raw)
  );

  gapr_ram #(.WIDTH(INFO_W), .DEPTH(RING_DEPTH)) u_info_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_info),
    .raddr (ram_raddr),
    .rdata (rd_info)
  );

  // Unpack the entry read last cycle
  assign rd_time   = $signed(rd_time_raw);
  assign rd_size   = rd_info[SIZE_W-1:0];
  assign rd_video  = rd_info[SIZE_W];
  assign rd_keyvid = rd_info[SIZE_W] && rd_info[SIZE_W+1];
  assign rd_gen    = rd_info[SIZE_W+2 +: GEN_W];

  assign c_time  = $signed(cmd_r.packet_time_ns);
  assign c_rin   = $signed(cmd_r.range_in_ns);
  assign c_rout  = $signed(cmd_r.range_out_ns);
  assign idx_inc = idx_r + CNT_W'(1);

  // Limit check against the current ring contents
  assign span      = newest_r - oldest_r;
  assign over_lim  = (total_r != '0) &&
                     (((max_bytes_r != '0) && (bytes_r > max_bytes_r)) ||
                      ((max_span_r != '0) && (span > {1'b0, max_span_r})));
  assign bytes_add = {1'b0, bytes_r} + {{(BYTE_W + 1 - SIZE_W){1'b0}}, cmd_r.packet_size};

  assign q_pop       = (state_r == S_IDLE) && q_head.valid;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_comb begin
    max_bytes_nxt = max_bytes_r;
    max_span_nxt  = max_span_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAX_BYTES: max_bytes_nxt = cfg_ch.data[BYTE_W-1:0];
        CFG_MAX_SPAN:  max_span_nxt  = cfg_ch.data[SPAN_W-1:0];
        default:       max_bytes_nxt = max_bytes_r;
      endcase
    end
  end

  // Sequencer for push, eviction and resolve scans
  always_comb begin
    logic r1_end;
    logic hk, hi, ho, fail;

    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    head_nxt     = head_r;
    total_nxt    = total_r;
    bytes_nxt    = bytes_r;
    newest_nxt   = newest_r;
    oldest_nxt   = oldest_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    ds_nxt       = ds_r;
    last_nxt     = last_r;
    ds_time_nxt  = ds_time_r;
    gen_nxt      = gen_r;
    have_key_nxt = have_key_r;
    have_in_nxt  = have_in_r;
    have_out_nxt = have_out_r;
    p_in_nxt     = p_in_r;
    p_out_nxt    = p_out_r;
    ok_nxt       = ok_r;
    ram_we       = 1'b0;
    r1_end       = 1'b0;
    hk           = have_key_r;
    hi           = have_in_r;
    ho           = have_out_r;
    fail         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          cmd_nxt   = q_head.cmd;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        unique case (cmd_r.kind)
          CMD_PUSH: begin
            if (total_r == CNT_W'(RING_DEPTH)) begin
              ok_nxt    = 1'b0;
              state_nxt = S_DONE;
            end else begin
              ram_we = 1'b1;
              if ((total_r == '0) || (c_time > newest_r)) begin
                newest_nxt = c_time;
              end
              if (total_r == '0) begin
                oldest_nxt = c_time;
              end
              bytes_nxt = bytes_add[BYTE_W] ? BYTE_MAX : bytes_add[BYTE_W-1:0];
              total_nxt = total_r + CNT_W'(1);
              state_nxt = S_EV_CHK;
            end
          end
          CMD_RESOLVE: begin
            if ((total_r == '0) || (c_rout < c_rin) || (c_rin < oldest_r) ||
                (c_rout > newest_r)) begin
              ok_nxt    = 1'b0;
              state_nxt = S_DONE;
            end else begin
              idx_nxt      = '0;
              have_key_nxt = 1'b0;
              state_nxt    = S_R1_RD;
            end
          end
          CMD_CLEAR: begin
            total_nxt  = '0;
            head_nxt   = '0;
            bytes_nxt  = '0;
            newest_nxt = '0;
            ok_nxt     = 1'b1;
            state_nxt  = S_DONE;
          end
          default: begin
            ok_nxt    = 1'b0;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_EV_CHK: begin
        if (over_lim) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_EV_RD;
        end else begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_EV_RD: state_nxt = S_EV_DAT;

      S_EV_DAT: begin
        if ((idx_r != '0) && rd_keyvid) begin
          // Drop the group in front of this keyframe
          head_nxt   = ram_raddr;
          total_nxt  = total_r - idx_r;
          bytes_nxt  = (bytes_r > sum_r) ? (bytes_r - sum_r) : '0;
          oldest_nxt = rd_time;
          state_nxt  = S_EV_CHK;
        end else begin
          sum_nxt = sum_r + {{(BYTE_W - SIZE_W){1'b0}}, rd_size};
          idx_nxt = idx_inc;
          if (idx_inc == total_r) begin
            ok_nxt    = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_EV_RD;
          end
        end
      end

      S_R1_RD: state_nxt = S_R1_DAT;

      S_R1_DAT: begin
        if (rd_keyvid) begin
          if (rd_time > c_rin) begin
            r1_end = 1'b1;
          end else begin
            ds_nxt      = idx_r;
            hk          = 1'b1;
            ds_time_nxt = rd_time;
            gen_nxt     = rd_gen;
          end
        end
        if (idx_inc == total_r) begin
          r1_end = 1'b1;
        end
        have_key_nxt = hk;
        idx_nxt      = idx_inc;
        if (r1_end) begin
          if (!hk) begin
            ok_nxt    = 1'b0;
            state_nxt = S_DONE;
          end else begin
            idx_nxt      = ds_nxt;
            last_nxt     = ds_nxt;
            have_in_nxt  = 1'b0;
            have_out_nxt = 1'b0;
            state_nxt    = S_R2_RD;
          end
        end else begin
          state_nxt = S_R1_RD;
        end
      end

      S_R2_RD: state_nxt = S_R2_DAT;

      S_R2_DAT: begin
        if (rd_time <= c_rout) begin
          if (rd_gen != gen_r) begin
            fail = 1'b1;
          end else begin
            last_nxt = idx_r;
            if (rd_video) begin
              if ((rd_time >= c_rin) && (!hi || (rd_time < p_in_r))) begin
                p_in_nxt = rd_time;
                hi       = 1'b1;
              end
              if (!ho || (rd_time > p_out_r)) begin
                p_out_nxt = rd_time;
                ho        = 1'b1;
              end
            end
          end
        end
        have_in_nxt  = hi;
        have_out_nxt = ho;
        idx_nxt      = idx_inc;
        if (fail) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else if (idx_inc == total_r) begin
          ok_nxt    = hi && ho;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_R2_RD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Drop a taken beat, load a new one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      total_r     <= '0;
      bytes_r     <= '0;
      newest_r    <= '0;
      max_bytes_r <= '0;
      max_span_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      bytes_r     <= bytes_nxt;
      newest_r    <= newest_nxt;
      max_bytes_r <= max_bytes_nxt;
      max_span_r  <= max_span_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the scans
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    oldest_r   <= oldest_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    ds_r       <= ds_nxt;
    last_r     <= last_nxt;
    ds_time_r  <= ds_time_nxt;
    gen_r      <= gen_nxt;
    have_key_r <= have_key_nxt;
    have_in_r  <= have_in_nxt;
    have_out_r <= have_out_nxt;
    p_in_r     <= p_in_nxt;
    p_out_r    <= p_out_nxt;
    ok_r       <= ok_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ok_r <= ok_r;
      if ((cmd_r.kind == CMD_RESOLVE) && ok_r) begin
        o_ds_idx_r   <= OUT_IDX_W'(ds_r);
        o_last_idx_r <= OUT_IDX_W'(last_r);
        o_ds_ns_r    <= ds_time_r;
        o_p_in_r     <= p_in_r;
        o_p_out_r    <= p_out_r;
        o_gen_r      <= gen_r;
      end else begin
        o_ds_idx_r   <= '0;
        o_last_idx_r <= '0;
        o_ds_ns_r    <= '0;
        o_p_in_r     <= '0;
        o_p_out_r    <= '0;
        o_gen_r      <= '0;
      end
      o_oldest_r <= (total_r != '0) ? oldest_r : '0;
      o_newest_r <= (total_r != '0) ? newest_r : '0;
      o_bytes_r  <= bytes_r;
      o_count_r  <= OUT_CNT_W'(total_r);
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.ok                 = o_ok_r;
  assign out_ch.decode_start_index = o_ds_idx_r;
  assign out_ch.last_index         = o_last_idx_r;
  assign out_ch.decode_start_ns    = o_ds_ns_r;
  assign out_ch.present_in_ns      = o_p_in_r;
  assign out_ch.present_out_ns     = o_p_out_r;
  assign out_ch.range_generation   = o_gen_r;
  assign out_ch.oldest_ns          = o_oldest_r;
  assign out_ch.newest_ns          = o_newest_r;
  assign out_ch.held_bytes         = o_bytes_r;
  assign out_ch.held_count         = o_count_r;

  `GAPR_ASSERT(a_count_bound, total_r <= CNT_W'(RING_DEPTH), "entry count above ring depth")
  `GAPR_ASSERT(a_empty_clean, (total_r == '0) |-> (bytes_r == '0 && newest_r == '0), "empty ring holds bytes or time")
  `GAPR_ASSERT(a_evict_keeps, (state_r == S_EV_DAT && state_nxt == S_EV_CHK) |=> (total_r != '0), "eviction emptied the ring")
  `GAPR_ASSERT_ALWAYS(a_load_free, (rst_n && state_r == S_DONE && !out_valid_r) |=> out_valid_r, "finished result not loaded")

endmodule
